/* rtl/fdsu_pkg.sv */
// ----------------------------------------------------------------------------
// fdsu_pkg
// Types and codes shared by the data stack unit modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fdsu_pkg;

  localparam int unsigned CellW  = 64;
  localparam int unsigned OpW    = 4;
  localparam int unsigned DepthW = 7;
  localparam int unsigned StatW  = 2;

  typedef enum logic [OpW-1:0] {
    OP_PUSH  = 4'd0,
    OP_DROP  = 4'd1,
    OP_DUP   = 4'd2,
    OP_QDUP  = 4'd3,
    OP_SWAP  = 4'd4,
    OP_OVER  = 4'd5,
    OP_ROT   = 4'd6,
    OP_MROT  = 4'd7,
    OP_DEPTH = 4'd8,
    OP_PICK  = 4'd9,
    OP_ROLL  = 4'd10
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_INDEX = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD0,
    S_RD1,
    S_RD2,
    S_RD3,
    S_EXEC,
    S_WR,
    S_PICK_RD,
    S_PICK_WR,
    S_ROLL_SAVE,
    S_ROLL_CAP,
    S_ROLL_RD,
    S_ROLL_WR,
    S_ROLL_END,
    S_TOP,
    S_TOPW
  } state_e;

  typedef struct packed {
    logic [OpW-1:0]          op;
    logic signed [CellW-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [CellW-1:0] top_value;
    logic [DepthW-1:0]       depth;
    logic [StatW-1:0]        status;
  } rsp_t;

endpackage

`default_nettype wire

/* rtl/fdsu_ram.sv */
// ----------------------------------------------------------------------------
// fdsu_ram
// Stack cell store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module fdsu_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [AddrW-1:0]           waddr_i,
  input  wire logic [fdsu_pkg::CellW-1:0] wdata_i,
  input  wire logic [AddrW-1:0]           raddr_i,
  output logic [fdsu_pkg::CellW-1:0]      rdata_o
);

  logic [fdsu_pkg::CellW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/fdsu_addsub.sv */
// ----------------------------------------------------------------------------
// fdsu_addsub
// Shared cell-wide adder/subtractor for addresses and index compares.
// ----------------------------------------------------------------------------
`default_nettype none

module fdsu_addsub (
  input  wire logic [fdsu_pkg::CellW-1:0] x_i,
  input  wire logic [fdsu_pkg::CellW-1:0] y_i,
  input  wire logic                       sub_i,
  output logic [fdsu_pkg::CellW-1:0]      sum_o,
  output logic                            borrow_o
);

  logic [fdsu_pkg::CellW:0]   full_sum;
  logic [fdsu_pkg::CellW-1:0] y_op;

  assign y_op     = sub_i ? ~y_i : y_i;
  assign full_sum = {1'b0, x_i} + {1'b0, y_op} + (fdsu_pkg::CellW + 1)'(sub_i);
  assign sum_o    = full_sum[fdsu_pkg::CellW-1:0];
  // x < y when subtracting and no carry comes out
  assign borrow_o = sub_i & ~full_sum[fdsu_pkg::CellW];

endmodule

`default_nettype wire

/* rtl/fdsu_ctrl.sv */
// ----------------------------------------------------------------------------
// fdsu_ctrl
// Sequencer: reads the top cells, decides the operation, writes the store,
// walks roll cell by cell and reads back the new top.
// ----------------------------------------------------------------------------
`default_nettype none

module fdsu_ctrl #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6,
  parameter int unsigned CntW  = 7
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire fdsu_pkg::req_t             req_i,
  output logic                            done_o,
  output fdsu_pkg::rsp_t                  rsp_o,
  // shared adder
  output logic [fdsu_pkg::CellW-1:0]      au_x_o,
  output logic [fdsu_pkg::CellW-1:0]      au_y_o,
  output logic                            au_sub_o,
  input  wire logic [fdsu_pkg::CellW-1:0] au_sum_i,
  input  wire logic                       au_borrow_i,
  // store
  output logic                            we_o,
  output logic [AddrW-1:0]                waddr_o,
  output logic [fdsu_pkg::CellW-1:0]      wdata_o,
  output logic [AddrW-1:0]                raddr_o,
  input  wire logic [fdsu_pkg::CellW-1:0] rdata_i
);

  localparam int unsigned CW = fdsu_pkg::CellW;

  fdsu_pkg::state_e state_q, state_d;

  logic [fdsu_pkg::OpW-1:0] op_q, op_d;
  logic [CW-1:0]            val_q, val_d;
  logic [CntW-1:0]          count_q, count_d;
  logic [CW-1:0]            t0_q, t0_d, t1_q, t1_d, t2_q, t2_d;
  logic [AddrW-1:0]         adr0_q, adr0_d, adr1_q, adr1_d, adr2_q, adr2_d;
  logic [AddrW-1:0]         ptr_q, ptr_d, nxt_q, nxt_d;
  logic [CW-1:0]            saved_q, saved_d;
  logic [AddrW-1:0]         wl_addr_q [3];
  logic [AddrW-1:0]         wl_addr_d [3];
  logic [CW-1:0]            wl_data_q [3];
  logic [CW-1:0]            wl_data_d [3];
  logic [1:0]               wl_n_q, wl_n_d;
  logic [fdsu_pkg::StatW-1:0] st_q, st_d;
  fdsu_pkg::rsp_t           rsp_q, rsp_d;
  logic                     done_q, done_d;

  // decision taken in the execute step
  logic                       empty, lt2, lt3, full, t0_zero, t0_lt2;
  logic [fdsu_pkg::StatW-1:0] ex_st;
  logic [CntW-1:0]            ex_count;
  logic [1:0]                 ex_wn;
  logic [AddrW-1:0]           ex_waddr [3];
  logic [CW-1:0]              ex_wdata [3];
  fdsu_pkg::state_e           ex_next;
  logic [AddrW-1:0]           push_addr;

  assign empty     = (count_q == '0);
  assign lt2       = (count_q < CntW'(2));
  assign lt3       = (count_q < CntW'(3));
  assign full      = (count_q >= CntW'(Depth));
  assign t0_zero   = (t0_q == '0);
  assign t0_lt2    = (t0_q[CW-1:1] == '0);
  assign push_addr = count_q[AddrW-1:0];

  always_comb begin
    ex_st       = fdsu_pkg::ST_OK;
    ex_count    = count_q;
    ex_wn       = 2'd0;
    ex_waddr[0] = push_addr;
    ex_waddr[1] = adr1_q;
    ex_waddr[2] = adr0_q;
    ex_wdata[0] = val_q;
    ex_wdata[1] = t0_q;
    ex_wdata[2] = t1_q;
    ex_next     = fdsu_pkg::S_TOP;
    case (op_q)
      fdsu_pkg::OP_PUSH: begin
        if (full) begin
          ex_st = fdsu_pkg::ST_OVER;
        end else begin
          ex_wn    = 2'd1;
          ex_count = count_q + CntW'(1);
        end
      end
      fdsu_pkg::OP_DROP: begin
        if (empty) begin
          ex_st = fdsu_pkg::ST_UNDER;
        end else begin
          ex_count = count_q - CntW'(1);
        end
      end
      fdsu_pkg::OP_DUP, fdsu_pkg::OP_QDUP: begin
        ex_wdata[0] = t0_q;
        if (empty) begin
          ex_st = fdsu_pkg::ST_UNDER;
        end else if (op_q == fdsu_pkg::OP_QDUP && t0_zero) begin
          ex_st = fdsu_pkg::ST_OK;
        end else if (full) begin
          ex_st = fdsu_pkg::ST_OVER;
        end else begin
          ex_wn    = 2'd1;
          ex_count = count_q + CntW'(1);
        end
      end
      fdsu_pkg::OP_SWAP: begin
        ex_waddr[0] = adr0_q;
        ex_wdata[0] = t1_q;
        ex_waddr[1] = adr1_q;
        ex_wdata[1] = t0_q;
        if (lt2) begin
          ex_st = fdsu_pkg::ST_UNDER;
        end else begin
          ex_wn = 2'd2;
        end
      end
      fdsu_pkg::OP_OVER: begin
        ex_wdata[0] = t1_q;
        if (lt2) begin
          ex_st = fdsu_pkg::ST_UNDER;
        end else if (full) begin
          ex_st = fdsu_pkg::ST_OVER;
        end else begin
          ex_wn    = 2'd1;
          ex_count = count_q + CntW'(1);
        end
      end
      fdsu_pkg::OP_ROT, fdsu_pkg::OP_MROT: begin
        ex_waddr[0] = adr2_q;
        ex_waddr[1] = adr1_q;
        ex_waddr[2] = adr0_q;
        if (op_q == fdsu_pkg::OP_ROT) begin
          ex_wdata[0] = t1_q;
          ex_wdata[1] = t0_q;
          ex_wdata[2] = t2_q;
        end else begin
          ex_wdata[0] = t0_q;
          ex_wdata[1] = t2_q;
          ex_wdata[2] = t1_q;
        end
        if (lt3) begin
          ex_st = fdsu_pkg::ST_UNDER;
        end else begin
          ex_wn = 2'd3;
        end
      end
      fdsu_pkg::OP_DEPTH: begin
        ex_wdata[0] = CW'(count_q);
        if (full) begin
          ex_st = fdsu_pkg::ST_OVER;
        end else begin
          ex_wn    = 2'd1;
          ex_count = count_q + CntW'(1);
        end
      end
      fdsu_pkg::OP_PICK: begin
        if (empty) begin
          ex_st = fdsu_pkg::ST_UNDER;
        end else if (t0_zero || au_borrow_i) begin
          ex_st = fdsu_pkg::ST_INDEX;
        end else begin
          ex_next = fdsu_pkg::S_PICK_RD;
        end
      end
      fdsu_pkg::OP_ROLL: begin
        if (empty) begin
          ex_st = fdsu_pkg::ST_UNDER;
        end else begin
          // the index is popped even when it is out of range
          ex_count = count_q - CntW'(1);
          if (au_borrow_i) begin
            ex_st = fdsu_pkg::ST_INDEX;
          end else if (!t0_lt2) begin
            ex_next = fdsu_pkg::S_ROLL_SAVE;
          end
        end
      end
      default: begin
        ex_st = fdsu_pkg::ST_OK;
      end
    endcase
    if (ex_wn != 2'd0) begin
      ex_next = fdsu_pkg::S_WR;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fdsu_pkg::S_IDLE:      if (start) state_d = fdsu_pkg::S_RD0;
      fdsu_pkg::S_RD0:       state_d = fdsu_pkg::S_RD1;
      fdsu_pkg::S_RD1:       state_d = fdsu_pkg::S_RD2;
      fdsu_pkg::S_RD2:       state_d = fdsu_pkg::S_RD3;
      fdsu_pkg::S_RD3:       state_d = fdsu_pkg::S_EXEC;
      fdsu_pkg::S_EXEC:      state_d = ex_next;
      fdsu_pkg::S_WR:        if (wl_n_q == 2'd1) state_d = fdsu_pkg::S_TOP;
      fdsu_pkg::S_PICK_RD:   state_d = fdsu_pkg::S_PICK_WR;
      fdsu_pkg::S_PICK_WR:   state_d = fdsu_pkg::S_TOP;
      fdsu_pkg::S_ROLL_SAVE: state_d = fdsu_pkg::S_ROLL_CAP;
      fdsu_pkg::S_ROLL_CAP:  state_d = fdsu_pkg::S_ROLL_WR;
      fdsu_pkg::S_ROLL_RD:   state_d = fdsu_pkg::S_ROLL_WR;
      fdsu_pkg::S_ROLL_WR: begin
        state_d = au_borrow_i ? fdsu_pkg::S_ROLL_RD : fdsu_pkg::S_ROLL_END;
      end
      fdsu_pkg::S_ROLL_END:  state_d = fdsu_pkg::S_TOP;
      fdsu_pkg::S_TOP:       state_d = fdsu_pkg::S_TOPW;
      fdsu_pkg::S_TOPW:      state_d = fdsu_pkg::S_IDLE;
      default:               state_d = fdsu_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    op_d      = op_q;
    val_d     = val_q;
    count_d   = count_q;
    t0_d      = t0_q;
    t1_d      = t1_q;
    t2_d      = t2_q;
    adr0_d    = adr0_q;
    adr1_d    = adr1_q;
    adr2_d    = adr2_q;
    ptr_d     = ptr_q;
    nxt_d     = nxt_q;
    saved_d   = saved_q;
    wl_addr_d = wl_addr_q;
    wl_data_d = wl_data_q;
    wl_n_d    = wl_n_q;
    st_d      = st_q;
    rsp_d     = rsp_q;
    done_d    = 1'b0;
    au_x_o    = '0;
    au_y_o    = '0;
    au_sub_o  = 1'b1;
    we_o      = 1'b0;
    waddr_o   = wl_addr_q[0];
    wdata_o   = wl_data_q[0];
    raddr_o   = au_sum_i[AddrW-1:0];
    case (state_q)
      fdsu_pkg::S_IDLE: begin
        if (start) begin
          op_d  = req_i.op;
          val_d = req_i.push_value;
        end
      end
      fdsu_pkg::S_RD0: begin
        au_x_o = CW'(count_q);
        au_y_o = CW'(1);
        adr0_d = au_sum_i[AddrW-1:0];
      end
      fdsu_pkg::S_RD1: begin
        au_x_o = CW'(count_q);
        au_y_o = CW'(2);
        adr1_d = au_sum_i[AddrW-1:0];
        t0_d   = rdata_i;
      end
      fdsu_pkg::S_RD2: begin
        au_x_o = CW'(count_q);
        au_y_o = CW'(3);
        adr2_d = au_sum_i[AddrW-1:0];
        t1_d   = rdata_i;
      end
      fdsu_pkg::S_RD3: begin
        t2_d = rdata_i;
      end
      fdsu_pkg::S_EXEC: begin
        // index against cells below it; difference is the source address
        au_x_o    = CW'(adr0_q);
        au_y_o    = t0_q;
        ptr_d     = au_sum_i[AddrW-1:0];
        st_d      = ex_st;
        count_d   = ex_count;
        wl_n_d    = ex_wn;
        wl_addr_d = ex_waddr;
        wl_data_d = ex_wdata;
      end
      fdsu_pkg::S_WR: begin
        we_o         = 1'b1;
        wl_addr_d[0] = wl_addr_q[1];
        wl_addr_d[1] = wl_addr_q[2];
        wl_data_d[0] = wl_data_q[1];
        wl_data_d[1] = wl_data_q[2];
        wl_n_d       = wl_n_q - 2'd1;
      end
      fdsu_pkg::S_PICK_RD: begin
        raddr_o = ptr_q;
      end
      fdsu_pkg::S_PICK_WR: begin
        we_o    = 1'b1;
        waddr_o = adr0_q;
        wdata_o = rdata_i;
      end
      fdsu_pkg::S_ROLL_SAVE: begin
        raddr_o = ptr_q;
      end
      fdsu_pkg::S_ROLL_CAP, fdsu_pkg::S_ROLL_RD: begin
        au_x_o   = CW'(ptr_q);
        au_y_o   = CW'(1);
        au_sub_o = 1'b0;
        nxt_d    = au_sum_i[AddrW-1:0];
        if (state_q == fdsu_pkg::S_ROLL_CAP) begin
          saved_d = rdata_i;
        end
      end
      fdsu_pkg::S_ROLL_WR: begin
        // keep going while the next slot is below the new top slot, under the index
        au_x_o  = CW'(nxt_q);
        au_y_o  = CW'(adr1_q);
        we_o    = 1'b1;
        waddr_o = ptr_q;
        wdata_o = rdata_i;
        ptr_d   = nxt_q;
      end
      fdsu_pkg::S_ROLL_END: begin
        we_o    = 1'b1;
        waddr_o = adr1_q;
        wdata_o = saved_q;
      end
      fdsu_pkg::S_TOP: begin
        au_x_o = CW'(count_q);
        au_y_o = CW'(1);
      end
      fdsu_pkg::S_TOPW: begin
        rsp_d.top_value = (count_q == '0) ? '0 : rdata_i;
        rsp_d.depth     = fdsu_pkg::DepthW'(count_q);
        rsp_d.status    = st_q;
        done_d          = 1'b1;
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fdsu_pkg::S_IDLE;
      count_q <= '0;
      wl_n_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      wl_n_q  <= wl_n_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    val_q     <= val_d;
    t0_q      <= t0_d;
    t1_q      <= t1_d;
    t2_q      <= t2_d;
    adr0_q    <= adr0_d;
    adr1_q    <= adr1_d;
    adr2_q    <= adr2_d;
    ptr_q     <= ptr_d;
    nxt_q     <= nxt_d;
    saved_q   <= saved_d;
    wl_addr_q <= wl_addr_d;
    wl_data_q <= wl_data_d;
    st_q      <= st_d;
    rsp_q     <= rsp_d;
  end

  assign busy   = (state_q != fdsu_pkg::S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("cell count beyond stack depth");

  a_count_only_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> $past(state_q) == fdsu_pkg::S_EXEC)
    else $error("cell count changed outside execute step");

  a_done_after_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q) == fdsu_pkg::S_TOPW)
    else $error("result strobe without top readback");

  a_write_list_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == fdsu_pkg::S_WR |-> wl_n_q != 2'd0)
    else $error("write step with empty write list");

  a_accept_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy && !done_o)
    else $error("accepted request did not start the sequence");
`endif

endmodule

`default_nettype wire

/* rtl/forth_data_stack_unit.sv */
// ----------------------------------------------------------------------------
// forth_data_stack_unit
// Forth data stack: push and the standard stack words over a cell store.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one result
// follows, shown for a single cycle with done_o high, and must be taken then.
// Each request runs through one sequencer that reads the top three cells, one
// store read per cycle, then writes any changed cells through its single
// write port and reads back the new top. PICK copies the picked cell over
// the index; n ROLL with n of 2 or more moves each cell by a read and then
// a write through the single read and write port. busy drops in the cycle
// that shows the result, so a new request can be taken there. Cells never
// written read as undefined, but are never returned.
// ----------------------------------------------------------------------------
`default_nettype none

module forth_data_stack_unit #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire fdsu_pkg::req_t req_i,
  output logic                done_o,
  output fdsu_pkg::rsp_t      rsp_o
);

  localparam int unsigned AddrW = $clog2(STACK_DEPTH);
  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);

  logic [fdsu_pkg::CellW-1:0] au_x, au_y, au_sum;
  logic                       au_sub, au_borrow;
  logic                       we;
  logic [AddrW-1:0]           waddr, raddr;
  logic [fdsu_pkg::CellW-1:0] wdata, rdata;

  fdsu_ctrl #(
    .Depth (STACK_DEPTH),
    .AddrW (AddrW),
    .CntW  (CntW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .au_x_o      (au_x),
    .au_y_o      (au_y),
    .au_sub_o    (au_sub),
    .au_sum_i    (au_sum),
    .au_borrow_i (au_borrow),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  fdsu_addsub u_addsub (
    .x_i      (au_x),
    .y_i      (au_y),
    .sub_i    (au_sub),
    .sum_o    (au_sum),
    .borrow_o (au_borrow)
  );

  fdsu_ram #(
    .Depth (STACK_DEPTH),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule

`default_nettype wire

/* tb/sv/forth_data_stack_unit_test.sv */
// ----------------------------------------------------------------------------
// forth_data_stack_unit_test
// Drives stack words into the data stack unit, with bursts and gaps, and checks
// each result against a stack kept alongside: top cell, depth and status.
// ----------------------------------------------------------------------------
`default_nettype none

module forth_data_stack_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fdsu_pkg::*;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned ClkPeriod   = 10;
  localparam int unsigned DrainCycles = 16;

  logic   clk_i = 1'b0;
  logic   rst_ni;
  logic   start;
  logic   busy;
  req_t   req_i;
  logic   done_o;
  rsp_t   rsp_o;

  // shadow stack, updated as each request is taken
  logic [CellW-1:0] shadow_cells [STACK_DEPTH];
  int unsigned      shadow_count = 0;

  rsp_t        expected_rsp_q [$];
  rsp_t        want_rsp;
  int unsigned fail_count    = 0;
  int unsigned requests_sent = 0;
  int unsigned burst_left    = 0;

  forth_data_stack_unit #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic status_e shadow_push(input logic [CellW-1:0] value);
    if (shadow_count >= STACK_DEPTH) begin
      return ST_OVER;
    end
    shadow_cells[shadow_count] = value;
    shadow_count++;
    return ST_OK;
  endfunction

  function automatic rsp_t apply_stack_word(input req_t rq);
    int unsigned      c;
    int unsigned      rest;
    int unsigned      from;
    int unsigned      i;
    logic [CellW-1:0] a;
    logic [CellW-1:0] b;
    logic [CellW-1:0] d;
    status_e          st;
    rsp_t             rs;
    c  = shadow_count;
    st = ST_OK;
    case (rq.op)
      OP_PUSH: begin
        st = shadow_push(rq.push_value);
      end
      OP_DROP: begin
        if (c < 1) st = ST_UNDER;
        else shadow_count = c - 1;
      end
      OP_DUP: begin
        if (c < 1) st = ST_UNDER;
        else st = shadow_push(shadow_cells[c-1]);
      end
      OP_QDUP: begin
        if (c < 1) st = ST_UNDER;
        else if (shadow_cells[c-1] != '0) st = shadow_push(shadow_cells[c-1]);
      end
      OP_SWAP: begin
        if (c < 2) begin
          st = ST_UNDER;
        end else begin
          a = shadow_cells[c-1];
          shadow_cells[c-1] = shadow_cells[c-2];
          shadow_cells[c-2] = a;
        end
      end
      OP_OVER: begin
        if (c < 2) st = ST_UNDER;
        else st = shadow_push(shadow_cells[c-2]);
      end
      OP_ROT, OP_MROT: begin
        if (c < 3) begin
          st = ST_UNDER;
        end else begin
          a = shadow_cells[c-3];
          b = shadow_cells[c-2];
          d = shadow_cells[c-1];
          if (rq.op == OP_ROT) begin
            shadow_cells[c-3] = b;
            shadow_cells[c-2] = d;
            shadow_cells[c-1] = a;
          end else begin
            shadow_cells[c-3] = d;
            shadow_cells[c-2] = a;
            shadow_cells[c-1] = b;
          end
        end
      end
      OP_DEPTH: begin
        st = shadow_push(CellW'(c));
      end
      OP_PICK: begin
        if (c < 1) begin
          st = ST_UNDER;
        end else begin
          a = shadow_cells[c-1];
          if (a < 1 || a > CellW'(c - 1)) st = ST_INDEX;
          else shadow_cells[c-1] = shadow_cells[c - 1 - a[31:0]];
        end
      end
      OP_ROLL: begin
        if (c < 1) begin
          st = ST_UNDER;
        end else begin
          // the index stays popped even when it is out of range
          a            = shadow_cells[c-1];
          rest         = c - 1;
          shadow_count = rest;
          if (a > CellW'(rest)) begin
            st = ST_INDEX;
          end else if (a >= 2) begin
            from = rest - a[31:0];
            b    = shadow_cells[from];
            for (i = from; i + 1 < rest; i++) shadow_cells[i] = shadow_cells[i+1];
            shadow_cells[rest-1] = b;
          end
        end
      end
      default: begin
        // unused codes leave the stack alone
      end
    endcase
    rs.top_value = (shadow_count > 0) ? shadow_cells[shadow_count-1] : '0;
    rs.depth     = DepthW'(shadow_count);
    rs.status    = st;
    return rs;
  endfunction

  function automatic logic [CellW-1:0] random_cell();
    logic signed [CellW-1:0] near_zero;
    case ($urandom_range(0, 7))
      0: return {1'b1, {(CellW-1){1'b0}}};
      1: return {1'b0, {(CellW-1){1'b1}}};
      2: return '0;
      3: begin
        near_zero = CellW'($urandom_range(0, 16));
        return near_zero - CellW'(8);
      end
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // index for pick or roll with 'below' cells under it, mostly in range
  function automatic logic [CellW-1:0] index_for(input int unsigned below);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (below == 0 || r == 0) return random_cell();
    if (r == 1) return CellW'(below + 1);
    if (r == 2) return '0;
    if (r == 3) return CellW'(below);
    return CellW'($urandom_range(1, (below < 6) ? below : 6));
  endfunction

  // called at a rising edge; returns at the edge where the request is taken
  task automatic send_request(input logic [OpW-1:0] op_code, input logic [CellW-1:0] value);
    req_t rq;
    rq.op         = op_code;
    rq.push_value = value;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    start <= 1'b1;
    req_i <= rq;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_rsp_q.push_back(apply_stack_word(rq));
    requests_sent++;
  endtask

  task automatic test_empty_stack();
    op_e needs_cells [9];
    needs_cells = '{OP_DROP, OP_DUP, OP_QDUP, OP_SWAP, OP_OVER,
                    OP_ROT, OP_MROT, OP_PICK, OP_ROLL};
    foreach (needs_cells[k]) send_request(needs_cells[k], random_cell());
    send_request('1, random_cell());
  endtask

  task automatic test_stack_words();
    send_request(OP_PUSH, {1'b0, {(CellW-1){1'b1}}});
    send_request(OP_PUSH, {1'b1, {(CellW-1){1'b0}}});
    send_request(OP_PUSH, '0);
    send_request(OP_QDUP, '1);
    send_request(OP_DROP, '1);
    send_request(OP_DUP, '0);
    send_request(OP_SWAP, '0);
    send_request(OP_OVER, '0);
    send_request(OP_ROT, '0);
    send_request(OP_MROT, '0);
    send_request(OP_DEPTH, '0);
    send_request(OP_PUSH, CellW'(2));
    send_request(OP_PICK, '0);
    send_request(OP_PUSH, '1);
    send_request(OP_PICK, '0);
    send_request(OP_PUSH, CellW'(3));
    send_request(OP_ROLL, '0);
    send_request(OP_PUSH, '0);
    send_request(OP_ROLL, '0);
  endtask

  task automatic test_full_stack();
    while (shadow_count < STACK_DEPTH) send_request(OP_PUSH, random_cell());
    send_request(OP_PUSH, random_cell());
    send_request(OP_DUP, random_cell());
    send_request(OP_OVER, random_cell());
    send_request(OP_DEPTH, random_cell());
    send_request(OP_DROP, random_cell());
    send_request(OP_PUSH, CellW'(STACK_DEPTH - 1));
    send_request(OP_QDUP, random_cell());
    // deepest pick and roll reach the bottom cell
    send_request(OP_PICK, random_cell());
    send_request(OP_DROP, random_cell());
    send_request(OP_PUSH, CellW'(STACK_DEPTH - 1));
    send_request(OP_ROLL, random_cell());
    send_request(OP_PUSH, CellW'(STACK_DEPTH));
    send_request(OP_ROLL, random_cell());
    while (shadow_count != 0) send_request(OP_DROP, random_cell());
    send_request(OP_DROP, random_cell());
  endtask

  task automatic test_random_words(input int unsigned goal);
    int unsigned    stop_at;
    int unsigned    dice;
    int unsigned    c;
    logic [OpW-1:0] word;
    stop_at = requests_sent + goal;
    while (requests_sent < stop_at) begin
      c    = shadow_count;
      dice = $urandom_range(0, 99);
      if (c > STACK_DEPTH - 6 && dice < 50) begin
        send_request(OP_DROP, random_cell());
      end else if ((c < 3 && dice < 40) || dice < 25) begin
        send_request(OP_PUSH, random_cell());
      end else if (dice < 60) begin
        word = OpW'($urandom_range(int'(OP_DROP), int'(OP_DEPTH)));
        send_request(word, random_cell());
      end else if (dice < 88) begin
        word = $urandom_range(0, 1) ? OP_PICK : OP_ROLL;
        send_request(OP_PUSH, index_for(c));
        send_request(word, random_cell());
      end else if (dice < 95) begin
        send_request(OpW'($urandom()), random_cell());
      end else if (dice == 95) begin
        // unwind, then poke the empty stack
        while (shadow_count != 0) send_request(OP_DROP, random_cell());
        send_request(OpW'($urandom_range(int'(OP_DROP), int'(OP_ROLL))), random_cell());
      end else begin
        // pick or roll on whatever sits on top
        send_request($urandom_range(0, 1) ? OP_PICK : OP_ROLL, random_cell());
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_rsp_q.size() == 0) begin
        $error("result with no request outstanding: top_value %h depth %0d status %0d",
               rsp_o.top_value, rsp_o.depth, rsp_o.status);
        fail_count++;
      end else begin
        want_rsp = expected_rsp_q.pop_front();
        if (rsp_o.top_value !== want_rsp.top_value) begin
          $error("top_value: expected %h, got %h", want_rsp.top_value, rsp_o.top_value);
          fail_count++;
        end
        if (rsp_o.depth !== want_rsp.depth) begin
          $error("depth: expected %0d, got %0d", want_rsp.depth, rsp_o.depth);
          fail_count++;
        end
        if (rsp_o.status !== want_rsp.status) begin
          $error("status: expected %0d, got %0d", want_rsp.status, rsp_o.status);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst_ni <= 1'b0;
    start  <= 1'b0;
    req_i  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_stack();
    test_stack_words();
    test_full_stack();
    test_random_words(600);

    start <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
